// ===== src/pbb_pkg.sv =====
// Shared constants and helpers for the page bitmap blitter.
// No dependencies; imported by the front, back and top-level modules.
package pbb_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_SET_CURSOR = 2'd0;
  localparam logic [1:0] CMD_START_ICON = 2'd1;
  localparam logic [1:0] CMD_IMAGE_BYTE = 2'd2;

  // Rows covered by one image byte (one page)
  localparam int BYTE_ROWS = 8;
  localparam int ROW_IDX_BITS = 3;
  localparam int PAGE_BITS = 6;

  // Index of the topmost set pixel (bit 7 is row 0); bits must be nonzero
  function automatic logic [ROW_IDX_BITS-1:0] top_row_idx(input logic [BYTE_ROWS-1:0] bits);
    logic [ROW_IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = BYTE_ROWS - 1; i >= 0; i--) begin
      if (bits[BYTE_ROWS-1-i]) begin
        idx = ROW_IDX_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/pbb_fifo.sv =====
// Small register-based queue between the command front end and the pixel back end.
// No package dependencies.
module pbb_fifo #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_BITS'(DEPTH));
  assign head_data = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/pbb_front.sv =====
// Command front end: cursor and icon bookkeeping, color register, job issue.
// Depends on pbb_pkg; feeds pbb_fifo.
module pbb_front
  import pbb_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int COLOR_BITS = 16,
  parameter int JOB_W = COLOR_BITS + 2 * COORD_BITS + BYTE_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [COORD_BITS-1:0] in_cursor_x,
  input  logic [COORD_BITS-1:0] in_cursor_y,
  input  logic [7:0]            in_icon_width,
  input  logic [7:0]            in_icon_height,
  input  logic [7:0]            in_image_byte,
  input  logic                  cfg_wr_en,
  input  logic [COLOR_BITS-1:0] cfg_wr_data,
  input  logic                  fifo_full,
  output logic                  job_push,
  output logic [JOB_W-1:0]      job_data
);

  localparam int SUM_BITS = ((COORD_BITS > 9) ? COORD_BITS : 9) + 1;

  logic [COLOR_BITS-1:0] draw_color_r;
  logic [COORD_BITS-1:0] cur_col_r, cur_col_nxt;
  logic [COORD_BITS-1:0] cur_row_r, cur_row_nxt;
  logic [COORD_BITS-1:0] origin_col_r, origin_col_nxt;
  logic [COORD_BITS-1:0] page_row_r, page_row_nxt;
  logic [7:0]            width_held_r, width_held_nxt;
  logic [7:0]            column_index_r, column_index_nxt;
  logic [PAGE_BITS-1:0]  pages_left_r, pages_left_nxt;
  logic                  icon_active_r, icon_active_nxt;

  logic                  accept;
  logic [PAGE_BITS-1:0]  pages;
  logic [8:0]            height_up;
  logic [8:0]            col_count;
  logic [PAGE_BITS-1:0]  pages_dec;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  assign height_up = {1'b0, in_icon_height} + 9'd7;
  assign pages     = height_up[8:3];
  assign col_count = {1'b0, column_index_r} + 9'd1;
  assign pages_dec = (pages_left_r != '0) ? pages_left_r - 1'b1 : pages_left_r;

  // Only image bytes with at least one set pixel become jobs
  assign job_push = accept && (in_command == CMD_IMAGE_BYTE) && icon_active_r
                    && (in_image_byte != '0);
  assign job_data = {draw_color_r, cur_col_r, page_row_r, in_image_byte};

  // Cursor and icon state update per transaction
  always_comb begin
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    origin_col_nxt   = origin_col_r;
    page_row_nxt     = page_row_r;
    width_held_nxt   = width_held_r;
    column_index_nxt = column_index_r;
    pages_left_nxt   = pages_left_r;
    icon_active_nxt  = icon_active_r;
    if (accept) begin
      unique case (in_command)
        CMD_SET_CURSOR: begin
          cur_col_nxt     = in_cursor_x;
          cur_row_nxt     = in_cursor_y;
          icon_active_nxt = 1'b0;
        end
        CMD_START_ICON: begin
          origin_col_nxt   = cur_col_r;
          page_row_nxt     = cur_row_r;
          width_held_nxt   = in_icon_width;
          column_index_nxt = '0;
          pages_left_nxt   = pages;
          icon_active_nxt  = 1'b0;
          if (pages != '0) begin
            if (in_icon_width == '0) begin
              // Zero width: skip straight past all pages
              cur_row_nxt    = COORD_BITS'(SUM_BITS'(cur_row_r)
                                           + SUM_BITS'({pages, 3'b000}));
              page_row_nxt   = cur_row_nxt;
              pages_left_nxt = '0;
            end else begin
              icon_active_nxt = 1'b1;
            end
          end
        end
        CMD_IMAGE_BYTE: begin
          if (icon_active_r) begin
            if (col_count >= {1'b0, width_held_r}) begin
              // End of page: back to origin column, down one page
              column_index_nxt = '0;
              cur_col_nxt      = origin_col_r;
              page_row_nxt     = page_row_r + COORD_BITS'(BYTE_ROWS);
              cur_row_nxt      = page_row_nxt;
              pages_left_nxt   = pages_dec;
              if (pages_dec == '0) begin
                icon_active_nxt = 1'b0;
              end
            end else begin
              column_index_nxt = col_count[7:0];
              cur_col_nxt      = cur_col_r + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_color_r   <= '0;
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      origin_col_r   <= '0;
      page_row_r     <= '0;
      width_held_r   <= '0;
      column_index_r <= '0;
      pages_left_r   <= '0;
      icon_active_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        draw_color_r <= cfg_wr_data;
      end
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      origin_col_r   <= origin_col_nxt;
      page_row_r     <= page_row_nxt;
      width_held_r   <= width_held_nxt;
      column_index_r <= column_index_nxt;
      pages_left_r   <= pages_left_nxt;
      icon_active_r  <= icon_active_nxt;
    end
  end

endmodule

// ===== src/pbb_back.sv =====
// Pixel back end: expands a byte job into pixel writes, one per unstalled cycle.
// Depends on pbb_pkg; reads from pbb_fifo.
module pbb_back
  import pbb_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int COLOR_BITS = 16,
  parameter int JOB_W = COLOR_BITS + 2 * COORD_BITS + BYTE_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fifo_empty,
  input  logic [JOB_W-1:0]      job_data,
  output logic                  job_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOR_BITS-1:0] out_pixel_color,
  output logic                  out_last_of_run
);

  // Current job
  logic                  job_vld_r, job_vld_nxt;
  logic [COLOR_BITS-1:0] job_color_r;
  logic [COORD_BITS-1:0] job_col_r;
  logic [COORD_BITS-1:0] job_row_r;
  logic [BYTE_ROWS-1:0]  job_bits_r, job_bits_nxt;

  // Output register
  logic                  out_vld_r, out_vld_nxt;
  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic [COLOR_BITS-1:0] pc_r;
  logic                  plast_r;

  logic                    advance;
  logic [ROW_IDX_BITS-1:0] row_idx;
  logic [BYTE_ROWS-1:0]    bits_left;
  logic                    job_done;

  assign row_idx   = top_row_idx(job_bits_r);
  assign bits_left = job_bits_r & ~(BYTE_ROWS'(1) << (BYTE_ROWS - 1 - int'(row_idx)));
  assign job_done  = (bits_left == '0);

  // Emit a pixel when the output register is free or being taken
  assign advance = job_vld_r && (!out_vld_r || !out_stall);
  assign job_pop = !fifo_empty && (!job_vld_r || (advance && job_done));

  always_comb begin
    job_vld_nxt  = job_vld_r;
    job_bits_nxt = job_bits_r;
    out_vld_nxt  = out_vld_r;
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
    if (advance) begin
      out_vld_nxt  = 1'b1;
      job_bits_nxt = bits_left;
      if (job_done) begin
        job_vld_nxt = 1'b0;
      end
    end
    if (job_pop) begin
      job_vld_nxt  = 1'b1;
      job_bits_nxt = job_data[BYTE_ROWS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      job_vld_r <= job_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_bits_r <= job_bits_nxt;
    if (job_pop) begin
      {job_color_r, job_col_r, job_row_r} <= job_data[JOB_W-1:BYTE_ROWS];
    end
    if (advance) begin
      px_r    <= job_col_r;
      py_r    <= job_row_r + COORD_BITS'(row_idx);
      pc_r    <= job_color_r;
      plast_r <= job_done;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = pc_r;
  assign out_last_of_run = plast_r;

endmodule

// ===== src/page_bitmap_blitter.sv =====
// Page bitmap blitter top level: front end, job queue and pixel back end.
// Depends on pbb_pkg, pbb_front, pbb_fifo and pbb_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries commands: set cursor, start
//   icon (width, height) and image bytes of eight vertical pixels, MSB on top.
//   Output channel (out_valid / out_stall) carries one pixel write per
//   transaction with its column, row, color and a flag on the last write of
//   each byte. cfg_wr_en / cfg_wr_data load the draw color.
//   Throughput: one input transaction per cycle while the job queue has room;
//   one pixel write per cycle on the output while the receiver does not
//   stall, so a byte yields one write per set bit (up to 8). The back end's
//   single output port sets the sustained rate.
//   A byte passes through the queue, the back end's job register and its
//   output register before its first pixel appears.
//   Bytes with no set pixels and all other commands produce no output.
//   Reset (synchronous, active low) clears cursor, icon state, color and the
//   queue; no clearing pass is needed.
//   When the receiver stalls, the held pixel stays put; the four-entry queue
//   fills and then in_stall rises until space frees up.
module page_bitmap_blitter
  import pbb_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int COLOR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [COORD_BITS-1:0] in_cursor_x,
  input  logic [COORD_BITS-1:0] in_cursor_y,
  input  logic [7:0]            in_icon_width,
  input  logic [7:0]            in_icon_height,
  input  logic [7:0]            in_image_byte,
  input  logic                  cfg_wr_en,
  input  logic [COLOR_BITS-1:0] cfg_wr_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOR_BITS-1:0] out_pixel_color,
  output logic                  out_last_of_run
);

  localparam int JOB_W = COLOR_BITS + 2 * COORD_BITS + BYTE_ROWS;
  localparam int QUEUE_DEPTH = 4;

  logic             job_push, job_pop;
  logic [JOB_W-1:0] push_data, head_data;
  logic             fifo_empty, fifo_full;

  pbb_front #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_cursor_x   (in_cursor_x),
    .in_cursor_y   (in_cursor_y),
    .in_icon_width (in_icon_width),
    .in_icon_height(in_icon_height),
    .in_image_byte (in_image_byte),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fifo_full     (fifo_full),
    .job_push      (job_push),
    .job_data      (push_data)
  );

  pbb_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(push_data),
    .pop      (job_pop),
    .head_data(head_data),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  pbb_back #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_empty     (fifo_empty),
    .job_data       (head_data),
    .job_pop        (job_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_of_run(out_last_of_run)
  );

endmodule
